// ----- sv/hsc_pkg.sv -----
// hsc_pkg: shared types, codes and bit-placement functions for the
// SECDED (31,26) codec. No dependencies.

package hsc_pkg;

   localparam int unsigned DATA_W   = 26;
   localparam int unsigned BODY_W   = 31;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned SYN_W    = 5;

   // check positions 1, 2, 4, 8, 16 live at bits 0, 1, 3, 7, 15
   localparam logic [BODY_W-1:0] CHECK_MASK = 31'h0000808B;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAN         = 2'd0,
      ST_CORRECTED     = 2'd1,
      ST_PARITY_BIT    = 2'd2,
      ST_UNCORRECTABLE = 2'd3
   } status_type;

   // front stage -> check stage
   typedef struct packed {
      op_type              op;
      logic [BODY_W-1:0]   body;
      logic [SYN_W-1:0]    syn;
      logic                par31;
   } front_type;

   // check stage -> fix stage
   typedef struct packed {
      op_type              op;
      logic [BODY_W-1:0]   body;
      logic [SYN_W-1:0]    syn;
      logic                flag;
   } check_type;

   // fix stage -> output
   typedef struct packed {
      logic [WORD_W-1:0]   result_word;
      status_type          status;
   } result_type;

   function automatic logic [BODY_W-1:0] scatter(input logic [DATA_W-1:0] data);
      logic [BODY_W-1:0] cw;
      int unsigned       d;
      cw = '0;
      d  = 0;
      for (int unsigned i = 0; i < BODY_W; i++) begin
         if (!CHECK_MASK[i]) begin
            cw[i] = data[d];
            d++;
         end
      end
      return cw;
   endfunction

   function automatic logic [DATA_W-1:0] gather(input logic [BODY_W-1:0] cw);
      logic [DATA_W-1:0] data;
      int unsigned       d;
      data = '0;
      d    = 0;
      for (int unsigned i = 0; i < BODY_W; i++) begin
         if (!CHECK_MASK[i]) begin
            data[d] = cw[i];
            d++;
         end
      end
      return data;
   endfunction

   // xor of the positions (bit index + 1) of all set bits
   function automatic logic [SYN_W-1:0] syndrome(input logic [BODY_W-1:0] cw);
      logic [SYN_W-1:0] s;
      s = '0;
      for (int unsigned i = 0; i < BODY_W; i++) begin
         if (cw[i]) begin
            s = s ^ SYN_W'(i + 1);
         end
      end
      return s;
   endfunction

endpackage

// ----- sv/hsc_if.sv -----
// hsc_if: valid/ready channel interfaces for the codec's request and
// response sides. Depends on hsc_pkg.

interface hsc_req_if;
   logic                           valid;
   logic                           ready;
   hsc_pkg::op_type                op;
   logic [hsc_pkg::WORD_W-1:0]     word;

   modport source (output valid, output op, output word, input ready);
   modport sink   (input valid, input op, input word, output ready);
endinterface

interface hsc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsc_pkg::WORD_W-1:0]     result_word;
   logic [1:0]                     status;

   modport source (output valid, output result_word, output status, input ready);
   modport sink   (input valid, input result_word, input status, output ready);
endinterface

// ----- sv/hamming_secded_31_26_codec_core.sv -----
// Top level of the SECDED (31,26) codec: three-stage pipeline.
// Depends on hsc_pkg, hsc_if, hsc_front, hsc_check and hsc_fix.

// Stateless single-error-correct, double-error-detect Hamming codec. Each
// transaction carries op (encode or decode) and a 32-bit word and yields one
// response. The block accepts one transaction every clock while the response
// side is ready and passes each result through three register stages
// (syndrome, check-bit and parity, correct and extract). A stalled response
// backs up through the stages with no loss, and req_bus.ready falls only
// when all stages hold data. Decode corrects the bit at the codeword
// position that the syndrome names, check positions included, and returns
// zero data with status 3 on a double error.

module hamming_secded_31_26_codec_core (
   input  logic        clock,
   input  logic        reset,
   hsc_req_if.sink     req_bus,
   hsc_rsp_if.source   rsp_bus
);

   logic                 front_valid;
   logic                 front_ready;
   hsc_pkg::front_type   front_data;
   logic                 check_valid;
   logic                 check_ready;
   hsc_pkg::check_type   check_data;
   hsc_pkg::result_type  result;

   hsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_op     (req_bus.op),
      .in_word   (req_bus.word),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   hsc_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (check_valid),
      .out_ready (check_ready),
      .out_data  (check_data)
   );

   hsc_fix u_fix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (check_valid),
      .in_ready  (check_ready),
      .in_data   (check_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (result)
   );

   assign rsp_bus.result_word = result.result_word;
   assign rsp_bus.status      = result.status;

endmodule

// ----- sv/hsc_front.sv -----
// hsc_front: first pipeline stage, places data bits (encode) or takes the
// received body (decode) and computes the syndrome. Depends on hsc_pkg.

module hsc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hsc_pkg::op_type            in_op,
   input  logic [hsc_pkg::WORD_W-1:0] in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hsc_pkg::front_type         out_data
);

   logic                 valid_ff;
   hsc_pkg::front_type   data_ff;
   hsc_pkg::front_type   data_in;
   logic [hsc_pkg::BODY_W-1:0] body;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_op == hsc_pkg::OP_DECODE) begin
         body = in_word[hsc_pkg::BODY_W-1:0];
      end else begin
         body = hsc_pkg::scatter(in_word[hsc_pkg::DATA_W-1:0]);
      end
      data_in.op    = in_op;
      data_in.body  = body;
      data_in.syn   = hsc_pkg::syndrome(body);
      data_in.par31 = (in_op == hsc_pkg::OP_DECODE) ? in_word[hsc_pkg::WORD_W-1] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/hsc_check.sv -----
// hsc_check: second pipeline stage, inserts check bits and overall parity
// on encode, computes the parity mismatch on decode. Depends on hsc_pkg.

module hsc_check (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsc_pkg::front_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsc_pkg::check_type  out_data
);

   logic                 valid_ff;
   hsc_pkg::check_type   data_ff;
   hsc_pkg::check_type   data_in;
   logic [hsc_pkg::BODY_W-1:0] cw;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      cw = in_data.body;
      if (in_data.op == hsc_pkg::OP_ENCODE) begin
         // check bit k goes to position 2^k
         cw[0]  = in_data.syn[0];
         cw[1]  = in_data.syn[1];
         cw[3]  = in_data.syn[2];
         cw[7]  = in_data.syn[3];
         cw[15] = in_data.syn[4];
      end
      data_in.op   = in_data.op;
      data_in.body = cw;
      data_in.syn  = in_data.syn;
      // encode: overall parity bit; decode: odd parity over all 32 bits
      data_in.flag = (^cw) ^ in_data.par31;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/hsc_fix.sv -----
// hsc_fix: last pipeline stage, corrects a single error, extracts data
// and sets the status; holds the output register. Depends on hsc_pkg.

module hsc_fix (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsc_pkg::check_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsc_pkg::result_type out_data
);

   logic                 valid_ff;
   hsc_pkg::result_type  data_ff;
   hsc_pkg::result_type  data_in;
   logic [hsc_pkg::BODY_W-1:0] flip;
   logic                 syn_zero;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      syn_zero = (in_data.syn == '0);
      flip     = hsc_pkg::BODY_W'(1) << (in_data.syn - hsc_pkg::SYN_W'(1));
      data_in.result_word = '0;
      data_in.status      = hsc_pkg::ST_CLEAN;
      if (in_data.op == hsc_pkg::OP_ENCODE) begin
         data_in.result_word = {in_data.flag, in_data.body};
      end else if (syn_zero) begin
         data_in.result_word = hsc_pkg::WORD_W'(hsc_pkg::gather(in_data.body));
         data_in.status = in_data.flag ? hsc_pkg::ST_PARITY_BIT : hsc_pkg::ST_CLEAN;
      end else if (in_data.flag) begin
         data_in.result_word = hsc_pkg::WORD_W'(hsc_pkg::gather(in_data.body ^ flip));
         data_in.status      = hsc_pkg::ST_CORRECTED;
      end else begin
         // nonzero syndrome with even parity: double error
         data_in.status = hsc_pkg::ST_UNCORRECTABLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/hsc_checker.sv -----
// hsc_checker: port-level assertions for the codec core, and the bind
// that attaches them. Depends on hsc_pkg and the core's interfaces.

module hsc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [hsc_pkg::WORD_W-1:0] rsp_result_word,
   input  logic [1:0]                 rsp_status
);

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_word) && $stable(rsp_status))
      else $error("stalled response changed");

   // response valid after an accepted request while the response side is open
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response missing after three cycles");

   // double error returns zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hsc_pkg::ST_UNCORRECTABLE |-> rsp_result_word == '0)
      else $error("uncorrectable word returned data");

   // any nonzero status is a decode, so only 26 data bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != hsc_pkg::ST_CLEAN |->
         rsp_result_word[hsc_pkg::WORD_W-1:hsc_pkg::DATA_W] == '0)
      else $error("decoded data has upper bits set");

endmodule

bind hamming_secded_31_26_codec_core hsc_checker u_hsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_word (rsp_bus.result_word),
   .rsp_status      (rsp_bus.status)
);

// ----- test/codec_result_check.sv -----
`timescale 1ns / 1ps
// codec_result_check: secded_calc package (bit placement and expected response
// per transaction) and a passive module that compares every response with it.
// Depends on hsc_pkg.

package secded_calc;
   import hsc_pkg::*;

   typedef struct packed {
      logic [31:0] result_word;
      status_type  status;
   } codec_response;

   // positions that are powers of two hold check bits
   function automatic bit is_check_bit(int idx);
      return ((idx + 1) & idx) == 0;
   endfunction

   function automatic logic [30:0] place_data(logic [25:0] data);
      logic [30:0] body;
      int          d;
      body = '0;
      d    = 0;
      for (int idx = 0; idx < 31; idx++) begin
         if (!is_check_bit(idx)) begin
            body[idx] = data[d];
            d++;
         end
      end
      return body;
   endfunction

   function automatic logic [25:0] pick_data(logic [30:0] body);
      logic [25:0] data;
      int          d;
      data = '0;
      d    = 0;
      for (int idx = 0; idx < 31; idx++) begin
         if (!is_check_bit(idx)) begin
            data[d] = body[idx];
            d++;
         end
      end
      return data;
   endfunction

   function automatic logic [4:0] position_xor(logic [30:0] body);
      logic [4:0] acc;
      acc = '0;
      for (int idx = 0; idx < 31; idx++) begin
         if (body[idx]) acc = acc ^ 5'(idx + 1);
      end
      return acc;
   endfunction

   function automatic logic [31:0] build_codeword(logic [25:0] data);
      logic [30:0] body;
      logic [4:0]  syn;
      body = place_data(data);
      syn  = position_xor(body);
      // check bits start at zero, so each takes its syndrome bit directly
      for (int k = 0; k < 5; k++) begin
         body[(1 << k) - 1] = syn[k];
      end
      return {^body, body};
   endfunction

   function automatic codec_response codec_response_of(op_type op, logic [31:0] word);
      codec_response r;
      logic [4:0]    syn;
      logic          odd;
      logic [31:0]   fixed;
      r.result_word = '0;
      r.status      = ST_CLEAN;
      if (op == OP_ENCODE) begin
         r.result_word = build_codeword(word[25:0]);
      end else begin
         syn = position_xor(word[30:0]);
         odd = ^word;
         if (syn == 5'd0) begin
            r.status      = odd ? ST_PARITY_BIT : ST_CLEAN;
            r.result_word = {6'd0, pick_data(word[30:0])};
         end else if (odd) begin
            fixed         = word ^ (32'd1 << (syn - 5'd1));
            r.status      = ST_CORRECTED;
            r.result_word = {6'd0, pick_data(fixed[30:0])};
         end else begin
            r.status = ST_UNCORRECTABLE;
         end
      end
      return r;
   endfunction
endpackage

module codec_result_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_result_word,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending
);
   import hsc_pkg::*;
   import secded_calc::*;

   codec_response pending_responses[$];
   int            errors;

   initial begin
      errors = 0;
   end

   always @(posedge clock) begin
      codec_response want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               errors++;
               $display("%0t: response with none expected: word %h status %0d",
                        $time, rsp_result_word, rsp_status);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_result_word !== want.result_word) begin
                  errors++;
                  $display("%0t: result_word expected %h actual %h",
                           $time, want.result_word, rsp_result_word);
               end
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_responses.push_back(codec_response_of(op_type'(req_op), req_word));
         end
      end
      pending    <= pending_responses.size();
      fail_count <= errors;
   end
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// testbench: drives encode and decode transactions into the SECDED codec and
// gives the verdict. Depends on hsc_pkg, hsc_if, the codec core and
// codec_result_check.

module testbench;
   import hsc_pkg::*;
   import secded_calc::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   steady_send;

   hsc_req_if req_bus();
   hsc_rsp_if rsp_bus();

   hamming_secded_31_26_codec_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   codec_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_op          (req_bus.op),
      .req_word        (req_bus.word),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_result_word (rsp_bus.result_word),
      .rsp_status      (rsp_bus.status),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one transaction: random gaps first, then hold until accepted
   task automatic offer_request(op_type op, logic [31:0] word);
      @(negedge clock);
      while (!steady_send && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.word  <= word;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // response side: random stalls, one long hold-off, one stall-free stretch
   initial begin
      int cycle;
      cycle         = 0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle >= 300 && cycle < 380)
            rsp_bus.ready <= 1'b0;
         else if (cycle >= 1000 && cycle < 1400)
            rsp_bus.ready <= 1'b1;
         else
            rsp_bus.ready <= ($urandom_range(99) >= 23);
      end
   end

   initial begin
      logic [31:0] cw;
      logic [31:0] word;
      op_type      op;
      int          pick;
      int          a;
      int          b;
      steady_send   = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_ENCODE;
      req_bus.word  = '0;
      reset         = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // encode extremes; bits above the data field must be ignored
      offer_request(OP_ENCODE, 32'h0000_0000);
      offer_request(OP_ENCODE, 32'h03FF_FFFF);
      offer_request(OP_ENCODE, 32'hFFFF_FFFF);
      offer_request(OP_ENCODE, 32'hFC00_0000);
      offer_request(OP_ENCODE, 32'h02AA_AAAA);
      offer_request(OP_ENCODE, 32'h0155_5555);
      offer_request(OP_ENCODE, 32'h0000_0001);

      // decode: clean words, single errors on check and data bits,
      // lone overall parity error, double errors
      offer_request(OP_DECODE, 32'h0000_0000);
      offer_request(OP_DECODE, 32'hFFFF_FFFF);
      cw = build_codeword(26'h234_5678);
      offer_request(OP_DECODE, cw);
      offer_request(OP_DECODE, cw ^ 32'h0000_0001);
      offer_request(OP_DECODE, cw ^ 32'h0000_0002);
      offer_request(OP_DECODE, cw ^ 32'h0000_8000);
      offer_request(OP_DECODE, cw ^ 32'h0000_0004);
      offer_request(OP_DECODE, cw ^ 32'h4000_0000);
      offer_request(OP_DECODE, cw ^ 32'h8000_0000);
      offer_request(OP_DECODE, cw ^ 32'h0000_0210);
      offer_request(OP_DECODE, cw ^ 32'h8000_0020);
      // three flips whose positions cancel: looks like a parity-bit error
      offer_request(OP_DECODE, cw ^ 32'h0000_0007);
      cw = build_codeword(26'h3FF_FFFF);
      offer_request(OP_DECODE, cw);
      offer_request(OP_DECODE, cw ^ 32'h0000_0080);
      offer_request(OP_DECODE, cw ^ 32'h4000_0001);

      for (int n = 0; n < 1350; n++) begin
         steady_send = (n >= 600 && n < 800);
         pick = $urandom_range(99);
         if (pick < 25) begin
            op   = OP_ENCODE;
            word = $urandom();
         end else begin
            op   = OP_DECODE;
            word = build_codeword(26'($urandom()));
            a    = $urandom_range(31);
            b    = (a + 1 + $urandom_range(30)) % 32;
            if (pick < 40)
               ;
            else if (pick < 70)
               word = word ^ (32'd1 << a);
            else if (pick < 90)
               word = word ^ (32'd1 << a) ^ (32'd1 << b);
            else
               word = $urandom();
         end
         offer_request(op, word);
      end
      steady_send = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
